FILE: rtl/rpn_pkg.sv
package rpn_pkg;

    // stack geometry
    localparam int STACK_DEPTH = 16;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    // payload widths
    localparam int DATA_W      = 32;
    localparam int CMD_W       = 3;
    localparam int COUNT_OUT_W = 5;
    localparam int STATUS_W    = 3;
    localparam int FRAC_W      = 16;
    localparam int QUO_W       = DATA_W + FRAC_W;
    localparam int DIV_CNT_W   = $clog2(QUO_W + 1);

    localparam logic [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    // command codes
    localparam logic [CMD_W-1:0] CMD_PUSH = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUL  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIV  = 3'd4;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_UNDERFLOW = 3'd1,
        ST_OVERFLOW  = 3'd2,
        ST_DIVZERO   = 3'd3,
        ST_SAT       = 3'd4
    } t_status;

    // microcode
    localparam int UPC_W = 5;

    typedef enum logic [1:0] {
        SQ_NEXT,
        SQ_JUMP,
        SQ_BRANCH,
        SQ_DONE
    } t_seq_op;

    typedef enum logic [1:0] {
        CND_FULL,
        CND_UNDER,
        CND_BZERO,
        CND_DBUSY
    } t_cond;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_PUSH,
        OP_RD_A,
        OP_ADD,
        OP_SUB,
        OP_MUL1,
        OP_MUL2,
        OP_DIV_START,
        OP_DIV_FIN,
        OP_DIVZ,
        OP_WRITE
    } t_dp_op;

    typedef enum logic {
        SEQ_IDLE,
        SEQ_RUN
    } t_seq_state;

    typedef struct packed {
        t_seq_op          seq;
        t_cond            cond;
        logic [UPC_W-1:0] target;
        t_dp_op           op;
        t_status          st;
    } t_uword;

    typedef struct packed {
        logic    accept;
        t_dp_op  op;
        logic    done;
        t_status done_st;
    } t_dp_ctl;

    typedef struct packed {
        logic full;
        logic under;
        logic b_zero;
        logic div_busy;
    } t_dp_flags;

    // program labels
    localparam logic [UPC_W-1:0] U_PUSH    = 5'd0;
    localparam logic [UPC_W-1:0] U_OK      = 5'd2;
    localparam logic [UPC_W-1:0] U_OVF     = 5'd3;
    localparam logic [UPC_W-1:0] U_UNF     = 5'd4;
    localparam logic [UPC_W-1:0] U_ADD     = 5'd5;
    localparam logic [UPC_W-1:0] U_WR      = 5'd7;
    localparam logic [UPC_W-1:0] U_SUB     = 5'd8;
    localparam logic [UPC_W-1:0] U_MUL     = 5'd10;
    localparam logic [UPC_W-1:0] U_DIV     = 5'd13;
    localparam logic [UPC_W-1:0] U_DWAIT   = 5'd16;
    localparam logic [UPC_W-1:0] U_DZ      = 5'd18;
    localparam logic [UPC_W-1:0] U_NONE    = 5'd0;

    function automatic t_uword mk(t_seq_op s, t_cond c, logic [UPC_W-1:0] t,
                                  t_dp_op o, t_status st);
        t_uword w;
        w.seq    = s;
        w.cond   = c;
        w.target = t;
        w.op     = o;
        w.st     = st;
        return w;
    endfunction

    // control store
    function automatic t_uword urom(logic [UPC_W-1:0] a);
        t_uword w;
        case (a)
            5'd0:  w = mk(SQ_BRANCH, CND_FULL,  U_OVF,   OP_NOP,       ST_OK);
            5'd1:  w = mk(SQ_NEXT,   CND_FULL,  U_NONE,  OP_PUSH,      ST_OK);
            5'd2:  w = mk(SQ_DONE,   CND_FULL,  U_NONE,  OP_NOP,       ST_OK);
            5'd3:  w = mk(SQ_DONE,   CND_FULL,  U_NONE,  OP_NOP,       ST_OVERFLOW);
            5'd4:  w = mk(SQ_DONE,   CND_FULL,  U_NONE,  OP_NOP,       ST_UNDERFLOW);
            5'd5:  w = mk(SQ_BRANCH, CND_UNDER, U_UNF,   OP_RD_A,      ST_OK);
            5'd6:  w = mk(SQ_NEXT,   CND_FULL,  U_NONE,  OP_ADD,       ST_OK);
            5'd7:  w = mk(SQ_JUMP,   CND_FULL,  U_OK,    OP_WRITE,     ST_OK);
            5'd8:  w = mk(SQ_BRANCH, CND_UNDER, U_UNF,   OP_RD_A,      ST_OK);
            5'd9:  w = mk(SQ_JUMP,   CND_FULL,  U_WR,    OP_SUB,       ST_OK);
            5'd10: w = mk(SQ_BRANCH, CND_UNDER, U_UNF,   OP_RD_A,      ST_OK);
            5'd11: w = mk(SQ_NEXT,   CND_FULL,  U_NONE,  OP_MUL1,      ST_OK);
            5'd12: w = mk(SQ_JUMP,   CND_FULL,  U_WR,    OP_MUL2,      ST_OK);
            5'd13: w = mk(SQ_BRANCH, CND_UNDER, U_UNF,   OP_RD_A,      ST_OK);
            5'd14: w = mk(SQ_BRANCH, CND_BZERO, U_DZ,    OP_NOP,       ST_OK);
            5'd15: w = mk(SQ_NEXT,   CND_FULL,  U_NONE,  OP_DIV_START, ST_OK);
            5'd16: w = mk(SQ_BRANCH, CND_DBUSY, U_DWAIT, OP_NOP,       ST_OK);
            5'd17: w = mk(SQ_JUMP,   CND_FULL,  U_WR,    OP_DIV_FIN,   ST_OK);
            5'd18: w = mk(SQ_NEXT,   CND_FULL,  U_NONE,  OP_DIVZ,      ST_OK);
            5'd19: w = mk(SQ_NEXT,   CND_FULL,  U_NONE,  OP_WRITE,     ST_OK);
            5'd20: w = mk(SQ_DONE,   CND_FULL,  U_NONE,  OP_NOP,       ST_DIVZERO);
            default: w = mk(SQ_DONE, CND_FULL,  U_NONE,  OP_NOP,       ST_OK);
        endcase
        return w;
    endfunction

    // dispatch on command
    function automatic logic [UPC_W-1:0] entry(logic [CMD_W-1:0] c);
        logic [UPC_W-1:0] e;
        case (c)
            CMD_PUSH: e = U_PUSH;
            CMD_ADD:  e = U_ADD;
            CMD_SUB:  e = U_SUB;
            CMD_MUL:  e = U_MUL;
            CMD_DIV:  e = U_DIV;
            default:  e = U_OK;
        endcase
        return e;
    endfunction

endpackage

FILE: rtl/rpn_div.sv
module rpn_div import rpn_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic signed [DATA_W-1:0] i_num,
    input  logic signed [DATA_W-1:0] i_den,
    output logic                     o_busy,
    output logic                     o_neg,
    output logic [QUO_W-1:0]         o_quot
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W-1:0]    r_rem;
    logic [QUO_W-1:0]     r_quo;
    logic [DATA_W-1:0]    r_den;
    logic                 r_neg;

    logic [DATA_W-1:0]    num_mag;
    logic [DATA_W-1:0]    den_mag;
    logic [DATA_W:0]      shifted;
    logic [DATA_W+1:0]    diff;
    logic                 fits;
    logic [DATA_W-1:0]    n_rem;
    logic [QUO_W-1:0]     n_quo;

    assign num_mag = i_num[DATA_W-1] ? (~i_num + 1'b1) : i_num;
    assign den_mag = i_den[DATA_W-1] ? (~i_den + 1'b1) : i_den;

    // one restoring step a cycle
    always_comb begin
        shifted = {r_rem, r_quo[QUO_W-1]};
        diff    = {1'b0, shifted} - {2'b00, r_den};
        fits    = ~diff[DATA_W+1];
        n_rem   = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
        n_quo   = {r_quo[QUO_W-2:0], fits};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(QUO_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= {num_mag, {FRAC_W{1'b0}}};
            r_den <= den_mag;
            r_neg <= i_num[DATA_W-1] ^ i_den[DATA_W-1];
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_busy = r_busy;
    assign o_neg  = r_neg;
    assign o_quot = r_quo;

endmodule

FILE: rtl/rpn_dp.sv
module rpn_dp import rpn_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_ctl                       i_ctl,
    input  logic signed [DATA_W-1:0]      i_value,
    output t_dp_flags                     o_flags,
    output logic                          o_valid,
    output logic signed [DATA_W-1:0]      o_top_value,
    output logic [COUNT_OUT_W-1:0]        o_stack_count,
    output logic [STATUS_W-1:0]           o_status
);

    logic [DATA_W-1:0]       mem [STACK_DEPTH];

    logic [CNT_W-1:0]        r_count;
    logic [DATA_W-1:0]       r_top;
    logic [DATA_W-1:0]       r_val;
    logic [DATA_W-1:0]       r_rdata;
    logic [DATA_W-1:0]       r_res;
    logic                    r_sat;
    logic signed [2*DATA_W-1:0] r_prod;

    logic                    r_out_valid;
    logic [DATA_W-1:0]       r_out_top;
    logic [COUNT_OUT_W-1:0]  r_out_cnt;
    t_status                 r_out_st;

    logic [PTR_W-1:0]        below_ptr;
    logic [PTR_W-1:0]        push_ptr;
    logic                    mem_we;
    logic [PTR_W-1:0]        mem_waddr;
    logic [DATA_W-1:0]       mem_wdata;

    logic signed [DATA_W-1:0] op_a;
    logic signed [DATA_W-1:0] op_b;
    logic [DATA_W:0]         sum;
    logic [DATA_W:0]         dif;
    logic [QUO_W-1:0]        scaled;
    logic                    div_busy;
    logic                    div_neg;
    logic [QUO_W-1:0]        quot;

    logic [DATA_W-1:0]       n_res;
    logic                    n_sat;
    logic                    res_load;
    t_status                 done_st;

    assign below_ptr = PTR_W'(r_count - CNT_W'(2));
    assign push_ptr  = PTR_W'(r_count);
    assign op_a      = r_rdata;
    assign op_b      = r_top;

    rpn_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_ctl.op == OP_DIV_START),
        .i_num   (op_a),
        .i_den   (op_b),
        .o_busy  (div_busy),
        .o_neg   (div_neg),
        .o_quot  (quot)
    );

    always_comb begin
        o_flags.full     = (r_count == CNT_W'(STACK_DEPTH));
        o_flags.under    = (r_count < CNT_W'(2));
        o_flags.b_zero   = (r_top == '0);
        o_flags.div_busy = div_busy;
    end

    // stack store
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = push_ptr;
        mem_wdata = r_val;
        if (i_ctl.op == OP_PUSH) begin
            mem_we = 1'b1;
        end else if (i_ctl.op == OP_WRITE) begin
            mem_we    = 1'b1;
            mem_waddr = below_ptr;
            mem_wdata = r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (i_ctl.op == OP_RD_A) begin
            r_rdata <= mem[below_ptr];
        end
    end

    // saturating arithmetic
    always_comb begin
        sum      = {op_a[DATA_W-1], op_a} + {op_b[DATA_W-1], op_b};
        dif      = {op_a[DATA_W-1], op_a} - {op_b[DATA_W-1], op_b};
        scaled   = r_prod[2*DATA_W-1:FRAC_W];
        n_res    = '0;
        n_sat    = 1'b0;
        res_load = 1'b1;
        unique case (i_ctl.op)
            OP_ADD: begin
                n_sat = sum[DATA_W] ^ sum[DATA_W-1];
                n_res = n_sat ? (sum[DATA_W] ? Q_MIN : Q_MAX) : sum[DATA_W-1:0];
            end
            OP_SUB: begin
                n_sat = dif[DATA_W] ^ dif[DATA_W-1];
                n_res = n_sat ? (dif[DATA_W] ? Q_MIN : Q_MAX) : dif[DATA_W-1:0];
            end
            OP_MUL2: begin
                if (!scaled[QUO_W-1] && (|scaled[QUO_W-2:DATA_W-1])) begin
                    n_sat = 1'b1;
                    n_res = Q_MAX;
                end else if (scaled[QUO_W-1] && !(&scaled[QUO_W-2:DATA_W-1])) begin
                    n_sat = 1'b1;
                    n_res = Q_MIN;
                end else begin
                    n_res = scaled[DATA_W-1:0];
                end
            end
            OP_DIV_FIN: begin
                if (!div_neg) begin
                    n_sat = |quot[QUO_W-1:DATA_W-1];
                    n_res = n_sat ? Q_MAX : quot[DATA_W-1:0];
                end else begin
                    n_sat = (|quot[QUO_W-1:DATA_W])
                          || (quot[DATA_W-1] && (|quot[DATA_W-2:0]));
                    n_res = n_sat ? Q_MIN : (~quot[DATA_W-1:0] + 1'b1);
                end
            end
            OP_DIVZ: begin
                n_res = op_a[DATA_W-1] ? Q_MIN : Q_MAX;
            end
            default: begin
                res_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_val <= i_value;
        end
        if (i_ctl.op == OP_MUL1) begin
            r_prod <= op_a * op_b;
        end
        if (res_load) begin
            r_res <= n_res;
        end
        if (i_ctl.op == OP_PUSH) begin
            r_top <= r_val;
        end else if (i_ctl.op == OP_WRITE) begin
            r_top <= r_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_sat   <= 1'b0;
        end else begin
            if (i_ctl.accept) begin
                r_sat <= 1'b0;
            end else if (res_load && n_sat) begin
                r_sat <= 1'b1;
            end
            if (i_ctl.op == OP_PUSH) begin
                r_count <= r_count + 1'b1;
            end else if (i_ctl.op == OP_WRITE) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // result register
    assign done_st = (i_ctl.done_st == ST_OK && r_sat) ? ST_SAT : i_ctl.done_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= i_ctl.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.done) begin
            r_out_top <= (r_count != '0) ? r_top : '0;
            r_out_cnt <= COUNT_OUT_W'(r_count);
            r_out_st  <= done_st;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_top_value   = r_out_top;
    assign o_stack_count = r_out_cnt;
    assign o_status      = r_out_st;

endmodule

FILE: rtl/rpn_seq.sv
module rpn_seq import rpn_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CMD_W-1:0] i_cmd,
    input  t_dp_flags        i_flags,
    output logic             o_busy,
    output t_dp_ctl          o_ctl
);

    t_seq_state       r_state;
    t_seq_state       n_state;
    logic [UPC_W-1:0] r_upc;
    logic [UPC_W-1:0] n_upc;
    t_uword           uw;
    logic             cond_hit;

    assign uw = urom(r_upc);

    always_comb begin
        unique case (uw.cond)
            CND_FULL:  cond_hit = i_flags.full;
            CND_UNDER: cond_hit = i_flags.under;
            CND_BZERO: cond_hit = i_flags.b_zero;
            CND_DBUSY: cond_hit = i_flags.div_busy;
        endcase
    end

    // next state and step counter
    always_comb begin
        n_state = r_state;
        n_upc   = r_upc;
        unique case (r_state)
            SEQ_IDLE: begin
                if (i_start) begin
                    n_state = SEQ_RUN;
                    n_upc   = entry(i_cmd);
                end
            end
            SEQ_RUN: begin
                unique case (uw.seq)
                    SQ_NEXT:   n_upc = r_upc + 1'b1;
                    SQ_JUMP:   n_upc = uw.target;
                    SQ_BRANCH: n_upc = cond_hit ? uw.target : r_upc + 1'b1;
                    SQ_DONE:   n_state = SEQ_IDLE;
                endcase
            end
        endcase
    end

    // control word out
    always_comb begin
        o_busy         = (r_state == SEQ_RUN);
        o_ctl.accept   = (r_state == SEQ_IDLE) && i_start;
        o_ctl.op       = (r_state == SEQ_RUN) ? uw.op : OP_NOP;
        o_ctl.done     = (r_state == SEQ_RUN) && (uw.seq == SQ_DONE);
        o_ctl.done_st  = uw.st;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_IDLE;
            r_upc   <= '0;
        end else begin
            r_state <= n_state;
            r_upc   <= n_upc;
        end
    end

endmodule

FILE: rtl/rpn_stack_calculator_top.sv
// one token at a time: busy stays high until the strobe, and a new start is taken
// at the edge ending the strobe cycle; no new token is taken before the last one's strobe
// synchronous active-low reset empties the stack and idles the sequencer; stack words
// keep their contents; the result strobe cannot be held off by the receiver
module rpn_stack_calculator_top import rpn_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [CMD_W-1:0]              i_cmd,
    input  logic signed [DATA_W-1:0]      i_value,
    output logic                          o_valid,
    output logic signed [DATA_W-1:0]      o_top_value,
    output logic [COUNT_OUT_W-1:0]        o_stack_count,
    output logic [STATUS_W-1:0]           o_status
);

    // control word from the microcode sequencer to the datapath
    t_dp_ctl   ctl;
    // branch conditions back from the datapath
    t_dp_flags flags;

    // step counter, control store and dispatch on the command code
    rpn_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_cmd   (i_cmd),
        .i_flags (flags),
        .o_busy  (busy),
        .o_ctl   (ctl)
    );

    // stack store, top register, saturating alu, divider and result register
    rpn_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .i_value       (i_value),
        .o_flags       (flags),
        .o_valid       (o_valid),
        .o_top_value   (o_top_value),
        .o_stack_count (o_stack_count),
        .o_status      (o_status)
    );

endmodule

FILE: rtl/rpn_chk.sv
module rpn_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic [2:0]  i_cmd,
    input logic [31:0] i_value,
    input logic        o_valid,
    input logic [31:0] o_top_value,
    input logic [4:0]  o_stack_count,
    input logic [2:0]  o_status
);

    // a taken beat keeps the block busy on the next cycle
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after an accepted beat");

    // the strobe comes with the block idle again
    a_valid_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("result strobe while busy");

    // busy ending always delivers a result
    a_fall_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (busy ##1 !busy) |-> o_valid)
        else $error("busy ended without a result");

    // never two results in a row
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("two result beats back to back");

    // an empty stack shows zero
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_stack_count == 5'd0) |-> (o_top_value == 32'd0))
        else $error("non-zero top on an empty stack");

endmodule

bind rpn_stack_calculator_top rpn_chk u_rpn_chk (.*);
